[rtl/btlv_pkg.sv]
// Shared types, constants and helpers of the b3dm tile layout validator.
// Used by every module of the block; depends on nothing else.
package btlv_pkg;

    localparam int HEADER_BYTES = 28;
    localparam int PAD_WINDOW   = 8;
    localparam int LEN_WORD_POS = 8;
    localparam int LEN_WORD_END = LEN_WORD_POS + 4;
    localparam int SUM_W        = 35;
    localparam int SIZE_W       = 33;
    localparam int END_W        = SUM_W + 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_END     = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_ALIGN   = 3'd5
    } t_status;

    typedef enum logic {
        CFG_SUPPORTED_VERSION = 1'b0,
        CFG_MAX_PADDING       = 1'b1
    } t_cfg_index;

    // Everything the back end needs to judge one finished tile.
    typedef struct packed {
        logic                    magic_ok;
        logic [31:0]             version;
        logic [31:0]             declared_length;
        logic [SUM_W-1:0]        section_sum;
        logic [31:0]             glb_length;
        logic [PAD_WINDOW-1:0]   nz_hist;
        logic [SIZE_W-1:0]       size;
    } t_tile_sum;

    typedef struct packed {
        logic short_tile;
        logic bad_magic;
        logic bad_version;
        logic bad_length;
        logic overrun;
        logic misaligned;
        logic no_glb;
        logic len_cut;
    } t_checks;

    typedef struct packed {
        t_checks                 checks;
        logic [SIZE_W-1:0]       size;
        logic [SUM_W-1:0]        section_sum;
        logic [31:0]             glb_length;
        logic [END_W-1:0]        glb_end;
        logic [PAD_WINDOW-1:0]   nz_hist;
    } t_judge;

    typedef struct packed {
        t_status     status;
        logic [31:0] glb_offset;
        logic [31:0] glb_length;
        logic [2:0]  padding_bytes;
        logic        glb_offset_aligned;
        logic        tile_length_aligned;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h62;
            2'd1: b = 8'h33;
            2'd2: b = 8'h64;
            2'd3: b = 8'h6D;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/b3dm_tile_layout_validator.sv]
// Top level of the b3dm tile layout validator: configuration registers and
// the front end, summary queue and back end. Uses btlv_pkg and the btlv_ modules.
//
// The block takes one tile byte per clock while full is low, with no gaps
// between tiles, and a tile may be as short as one byte. A word is accepted
// when push is high and full is low; each tile gives one result word, taken
// when pop is high and empty is low. A result passes through the summary queue,
// the stage A register and the result queue before it can be popped.
// The summary queue and the result queue are two words deep each, so either
// side can stall for a while without stopping the other. Configuration
// writes take effect at once and are meant for times when no tile is in
// flight.
module b3dm_tile_layout_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [31:0] o_glb_offset,
    output logic [31:0] o_glb_length,
    output logic [2:0]  o_padding_bytes,
    output logic        o_glb_offset_aligned,
    output logic        o_tile_length_aligned,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import btlv_pkg::*;

    logic [31:0] r_supported_version;
    logic [2:0]  r_max_padding;
    logic        accept, sum_push, sum_empty, sum_pop;
    t_tile_sum   front_sum, queue_sum;
    t_result     result;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supported_version <= 32'd1;
            r_max_padding       <= 3'd7;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_idx))
                CFG_SUPPORTED_VERSION: r_supported_version <= i_cfg_data;
                CFG_MAX_PADDING:       r_max_padding       <= i_cfg_data[2:0];
                default:               r_max_padding       <= r_max_padding;
            endcase
        end
    end

    btlv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_sum_push  (sum_push),
        .o_sum       (front_sum)
    );

    btlv_sum_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sum_push),
        .i_data  (front_sum),
        .o_full  (full),
        .o_empty (sum_empty),
        .i_pop   (sum_pop),
        .o_data  (queue_sum)
    );

    btlv_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_sum_valid         (!sum_empty),
        .i_sum               (queue_sum),
        .o_sum_pop           (sum_pop),
        .i_supported_version (r_supported_version),
        .i_max_padding       (r_max_padding),
        .i_pop               (pop),
        .o_empty             (empty),
        .o_result            (result)
    );

    assign o_status              = result.status;
    assign o_glb_offset          = result.glb_offset;
    assign o_glb_length          = result.glb_length;
    assign o_padding_bytes       = result.padding_bytes;
    assign o_glb_offset_aligned  = result.glb_offset_aligned;
    assign o_tile_length_aligned = result.tile_length_aligned;

endmodule

[rtl/btlv_front.sv]
// Front end: takes one tile byte per accepted cycle, captures the header words and the
// GLB length word, and emits a tile summary on the last byte. Uses btlv_pkg.
module btlv_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_sum_push,
    output btlv_pkg::t_tile_sum o_sum
);
    import btlv_pkg::*;

    logic [31:0]           r_byte_count, n_byte_count;
    logic                  r_magic_ok, n_magic_ok;
    logic [31:0]           r_version, n_version;
    logic [31:0]           r_decl_len, n_decl_len;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [SUM_W-1:0]      r_sum8, n_sum8;
    logic [31:0]           r_glb_len, n_glb_len;
    logic [PAD_WINDOW-1:0] r_hist, n_hist;

    logic [31:0]           u_byte_count;
    logic                  u_magic_ok;
    logic [31:0]           u_version;
    logic [31:0]           u_decl_len;
    logic [SUM_W-1:0]      u_sum;
    logic [SUM_W-1:0]      u_sum8;
    logic [31:0]           u_glb_len;
    logic [PAD_WINDOW-1:0] u_hist;

    logic [4:0]            lane_sh;
    logic [31:0]           word_bits;
    logic [SUM_W-1:0]      sum_bits;
    logic [END_W-1:0]      len_dist;
    logic [4:0]            glb_sh;
    logic                  in_magic, in_version, in_length, in_sections, in_glb_word;

    always_comb begin
        lane_sh   = {r_byte_count[1:0], 3'b000};
        word_bits = 32'(i_data_byte) << lane_sh;
        sum_bits  = SUM_W'(i_data_byte) << lane_sh;
        // Distance of this byte from the GLB length word; valid once the header is done.
        len_dist  = {4'b0000, r_byte_count} - {1'b0, r_sum8};
        glb_sh    = {len_dist[1:0], 3'b000};

        in_magic    = (r_byte_count < 32'd4);
        in_version  = !in_magic && (r_byte_count < 32'(LEN_WORD_POS));
        in_length   = (r_byte_count >= 32'(LEN_WORD_POS)) && (r_byte_count < 32'(LEN_WORD_END));
        in_sections = (r_byte_count >= 32'(LEN_WORD_END)) && (r_byte_count < 32'(HEADER_BYTES));
        in_glb_word = (r_byte_count >= 32'(HEADER_BYTES)) && (len_dist[END_W-1:2] == '0);

        u_magic_ok = r_magic_ok;
        u_version  = r_version;
        u_decl_len = r_decl_len;
        u_sum      = r_sum;
        u_sum8     = r_sum8;
        u_glb_len  = r_glb_len;
        priority if (in_magic) begin
            if (i_data_byte != magic_byte(r_byte_count[1:0])) u_magic_ok = 1'b0;
        end else if (in_version) begin
            u_version = r_version | word_bits;
        end else if (in_length) begin
            u_decl_len = r_decl_len | word_bits;
        end else if (in_sections) begin
            u_sum  = r_sum + sum_bits;
            u_sum8 = r_sum8 + sum_bits;
        end else if (in_glb_word) begin
            u_glb_len = r_glb_len | (32'(i_data_byte) << glb_sh);
        end

        u_hist       = {r_hist[PAD_WINDOW-2:0], (i_data_byte != 8'h00)};
        u_byte_count = (r_byte_count == '1) ? r_byte_count : r_byte_count + 32'd1;

        o_sum.magic_ok        = u_magic_ok;
        o_sum.version         = u_version;
        o_sum.declared_length = u_decl_len;
        o_sum.section_sum     = u_sum;
        o_sum.glb_length      = u_glb_len;
        o_sum.nz_hist         = u_hist;
        // A saturated counter still gives a size of two to the 32nd.
        o_sum.size            = {1'b0, r_byte_count} + SIZE_W'(1);
        o_sum_push            = i_accept && i_last_byte;

        n_byte_count = r_byte_count;
        n_magic_ok   = r_magic_ok;
        n_version    = r_version;
        n_decl_len   = r_decl_len;
        n_sum        = r_sum;
        n_sum8       = r_sum8;
        n_glb_len    = r_glb_len;
        n_hist       = r_hist;
        if (i_accept && i_last_byte) begin
            n_byte_count = '0;
            n_magic_ok   = 1'b1;
            n_version    = '0;
            n_decl_len   = '0;
            n_sum        = SUM_W'(HEADER_BYTES);
            n_sum8       = SUM_W'(HEADER_BYTES + LEN_WORD_POS);
            n_glb_len    = '0;
            n_hist       = '0;
        end else if (i_accept) begin
            n_byte_count = u_byte_count;
            n_magic_ok   = u_magic_ok;
            n_version    = u_version;
            n_decl_len   = u_decl_len;
            n_sum        = u_sum;
            n_sum8       = u_sum8;
            n_glb_len    = u_glb_len;
            n_hist       = u_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_magic_ok   <= 1'b1;
            r_version    <= '0;
            r_decl_len   <= '0;
            r_sum        <= SUM_W'(HEADER_BYTES);
            r_sum8       <= SUM_W'(HEADER_BYTES + LEN_WORD_POS);
            r_glb_len    <= '0;
            r_hist       <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_magic_ok   <= n_magic_ok;
            r_version    <= n_version;
            r_decl_len   <= n_decl_len;
            r_sum        <= n_sum;
            r_sum8       <= n_sum8;
            r_glb_len    <= n_glb_len;
            r_hist       <= n_hist;
        end
    end

`ifndef SYNTH
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=>
            (r_byte_count == '0 && r_sum == SUM_W'(HEADER_BYTES) && r_hist == '0))
        else $error("front state not restarted after the last byte of a tile");
`endif

endmodule

[rtl/btlv_sum_queue.sv]
// Short queue of tile summaries between the front and back ends.
// Uses btlv_pkg for the summary type and the depth.
module btlv_sum_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  btlv_pkg::t_tile_sum i_data,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_pop,
    output btlv_pkg::t_tile_sum o_data
);
    import btlv_pkg::*;

    t_tile_sum         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    always_comb begin
        o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
        o_empty = (r_cnt == '0);
        o_data  = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
        if (do_pop)  n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
        if (do_push && !do_pop) n_cnt = r_cnt + QCNT_W'(1);
        else if (do_pop && !do_push) n_cnt = r_cnt - QCNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/btlv_back.sv]
// Back end: judges each tile summary in two stages and holds the results in
// a short output queue. Uses btlv_pkg.
module btlv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sum_valid,
    input  btlv_pkg::t_tile_sum i_sum,
    output logic                o_sum_pop,
    input  logic [31:0]         i_supported_version,
    input  logic [2:0]          i_max_padding,
    input  logic                i_pop,
    output logic                o_empty,
    output btlv_pkg::t_result   o_result
);
    import btlv_pkg::*;

    t_judge            r_a, n_a;
    logic              r_a_valid, n_a_valid;
    t_result           r_oq [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_oq_wr, n_oq_wr;
    logic [QPTR_W-1:0] r_oq_rd, n_oq_rd;
    logic [QCNT_W-1:0] r_oq_cnt, n_oq_cnt;

    logic                  oq_room, oq_pop, a_load, b_move;
    logic [SIZE_W+3:0]     trail_diff;
    logic [END_W-1:0]      trailing;
    logic                  glb_over, too_much_pad, past_window, pad_nonzero;
    logic [PAD_WINDOW-1:0] pad_mask;
    t_result               b_res;

    // Stage A: the checks that need only the summary and the configuration.
    always_comb begin
        n_a.checks.short_tile  = (i_sum.size < SIZE_W'(HEADER_BYTES));
        n_a.checks.bad_magic   = !i_sum.magic_ok;
        n_a.checks.bad_version = (i_sum.version != i_supported_version);
        n_a.checks.bad_length  = ({1'b0, i_sum.declared_length} != i_sum.size);
        n_a.checks.overrun     = (i_sum.section_sum > SUM_W'(i_sum.size));
        n_a.checks.misaligned  = (i_sum.section_sum[1:0] != 2'b00) || (i_sum.size[1:0] != 2'b00);
        n_a.checks.no_glb      = (i_sum.section_sum >= SUM_W'(i_sum.size));
        n_a.checks.len_cut     = ((i_sum.section_sum + SUM_W'(LEN_WORD_END)) > SUM_W'(i_sum.size));
        n_a.size        = i_sum.size;
        n_a.section_sum = i_sum.section_sum;
        n_a.glb_length  = i_sum.glb_length;
        n_a.glb_end     = {1'b0, i_sum.section_sum} + END_W'(i_sum.glb_length);
        n_a.nz_hist     = i_sum.nz_hist;
    end

    // Stage B: trailing byte count, padding checks and the status in check order.
    always_comb begin
        trail_diff   = {4'b0000, r_a.size} - {1'b0, r_a.glb_end};
        glb_over     = trail_diff[SIZE_W+3];
        trailing     = trail_diff[END_W-1:0];
        too_much_pad = (trailing > END_W'(i_max_padding));
        past_window  = (trailing > END_W'(PAD_WINDOW));
        for (int i = 0; i < PAD_WINDOW; i++) begin
            pad_mask[i] = (END_W'(i) < trailing);
        end
        pad_nonzero = |(r_a.nz_hist & pad_mask);

        b_res = '0;
        priority if (r_a.checks.short_tile)  b_res.status = ST_END;
        else if (r_a.checks.bad_magic)       b_res.status = ST_MAGIC;
        else if (r_a.checks.bad_version)     b_res.status = ST_VERSION;
        else if (r_a.checks.bad_length)      b_res.status = ST_LENGTH;
        else if (r_a.checks.overrun)         b_res.status = ST_END;
        else if (r_a.checks.misaligned)      b_res.status = ST_ALIGN;
        else if (r_a.checks.no_glb)          b_res.status = ST_END;
        else if (r_a.checks.len_cut)         b_res.status = ST_END;
        else if (glb_over)                   b_res.status = ST_END;
        else if (too_much_pad)               b_res.status = ST_LENGTH;
        else if (past_window)                b_res.status = ST_LENGTH;
        else if (pad_nonzero)                b_res.status = ST_LENGTH;
        else begin
            b_res.status              = ST_OK;
            b_res.glb_offset          = r_a.section_sum[31:0];
            b_res.glb_length          = r_a.glb_length;
            b_res.padding_bytes       = trailing[2:0];
            b_res.glb_offset_aligned  = (r_a.section_sum[2:0] == 3'b000);
            b_res.tile_length_aligned = (r_a.size[2:0] == 3'b000);
        end
    end

    always_comb begin
        o_empty  = (r_oq_cnt == '0);
        o_result = r_oq[r_oq_rd];
        oq_pop   = i_pop && !o_empty;
        oq_room  = (r_oq_cnt != QCNT_W'(QUEUE_DEPTH)) || oq_pop;
        b_move   = r_a_valid && oq_room;
        a_load   = i_sum_valid && (!r_a_valid || oq_room);
        o_sum_pop = a_load;

        n_a_valid = r_a_valid;
        if (a_load) n_a_valid = 1'b1;
        else if (b_move) n_a_valid = 1'b0;

        n_oq_wr  = r_oq_wr;
        n_oq_rd  = r_oq_rd;
        n_oq_cnt = r_oq_cnt;
        if (b_move) n_oq_wr = (r_oq_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_oq_wr + QPTR_W'(1);
        if (oq_pop) n_oq_rd = (r_oq_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_oq_rd + QPTR_W'(1);
        if (b_move && !oq_pop) n_oq_cnt = r_oq_cnt + QCNT_W'(1);
        else if (oq_pop && !b_move) n_oq_cnt = r_oq_cnt - QCNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (a_load) r_a <= n_a;
        if (b_move) r_oq[r_oq_wr] <= b_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_oq_wr   <= '0;
            r_oq_rd   <= '0;
            r_oq_cnt  <= '0;
        end else begin
            r_a_valid <= n_a_valid;
            r_oq_wr   <= n_oq_wr;
            r_oq_rd   <= n_oq_rd;
            r_oq_cnt  <= n_oq_cnt;
        end
    end

`ifndef SYNTH
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count above its depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.status != ST_OK) |->
            (o_result.glb_offset == '0 && o_result.glb_length == '0 &&
             o_result.padding_bytes == '0 && !o_result.glb_offset_aligned &&
             !o_result.tile_length_aligned))
        else $error("failed tile carries layout fields");

    a_ok_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.status == ST_OK) |-> (o_result.glb_offset[1:0] == 2'b00))
        else $error("accepted tile has a GLB offset that is not word aligned");
`endif

endmodule

[bench/tb_b3dm_tile_layout_validator.sv]
// Self-checking testbench for the b3dm tile layout validator: builds tiles byte by byte,
// predicts each tile's verdict and checks every result word. Depends on btlv_pkg and
// the b3dm_tile_layout_validator top level.
`timescale 1ns / 100ps

module tb_b3dm_tile_layout_validator;
    import btlv_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 400;

    // Kinds of tile the stimulus can build: well formed, one layout fault each, or noise.
    typedef enum int {
        FLT_NONE,
        FLT_MAGIC,
        FLT_VERSION,
        FLT_LENGTH,
        FLT_MISALIGN,
        FLT_ODD_SIZE,
        FLT_OVERRUN,
        FLT_NO_GLB,
        FLT_LEN_CUT,
        FLT_GLB_OVERRUN,
        FLT_PAD_MANY,
        FLT_PAD_NZ,
        FLT_SHORT,
        FLT_NOISE
    } tile_fault_t;

    typedef struct {
        tile_fault_t fault;
        bit          use_arg;
        logic [31:0] arg;
        bit          typed;
        t_status     status;
    } probe_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_glb_offset;
    logic [31:0] o_glb_length;
    logic [2:0]  o_padding_bytes;
    logic        o_glb_offset_aligned;
    logic        o_tile_length_aligned;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_SUPPORTED_VERSION;
    logic [31:0] i_cfg_data = 32'd0;

    b3dm_tile_layout_validator dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .push                 (push),
        .full                 (full),
        .i_data_byte          (i_data_byte),
        .i_last_byte          (i_last_byte),
        .empty                (empty),
        .pop                  (pop),
        .o_status             (o_status),
        .o_glb_offset         (o_glb_offset),
        .o_glb_length         (o_glb_length),
        .o_padding_bytes      (o_padding_bytes),
        .o_glb_offset_aligned (o_glb_offset_aligned),
        .o_tile_length_aligned(o_tile_length_aligned),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data)
    );

    localparam logic [7:0] TILE_MAGIC [4] = '{8'h62, 8'h33, 8'h64, 8'h6D};

    // Configuration as the block should currently hold it.
    logic [31:0] cfg_version = 32'd1;
    logic [2:0]  cfg_max_pad = 3'd7;

    // Running state of the tile being tracked.
    logic [31:0]       trk_count = '0;
    logic [4:0]        trk_shift = '0;
    logic              trk_magic_ok = 1'b1;
    logic [31:0]       trk_version = '0;
    logic [31:0]       trk_declared = '0;
    logic [SUM_W-1:0]  trk_sum = SUM_W'(HEADER_BYTES);
    logic [31:0]       trk_glb_len = '0;
    logic [7:0]        trk_nz = '0;

    t_result    awaited_verdicts [$];
    logic [7:0] tile_bytes [$];

    int  mismatches = 0;
    int  bytes_sent = 0;
    int  tiles_sent = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_left = 0;
    bit  hold_request = 1'b0;

    probe_row_t probe_table [18] = '{
        '{FLT_NOISE,       1'b1, 32'h0000_0000, 1'b1, ST_END},
        '{FLT_NOISE,       1'b1, 32'h0000_00FF, 1'b1, ST_END},
        '{FLT_SHORT,       1'b1, 32'd27,        1'b1, ST_END},
        '{FLT_MAGIC,       1'b0, 32'd0,         1'b1, ST_MAGIC},
        '{FLT_VERSION,     1'b1, 32'h0000_0000, 1'b1, ST_VERSION},
        '{FLT_VERSION,     1'b1, 32'hFFFF_FFFF, 1'b1, ST_VERSION},
        '{FLT_LENGTH,      1'b0, 32'd0,         1'b1, ST_LENGTH},
        '{FLT_OVERRUN,     1'b1, 32'hFFFF_FFFF, 1'b1, ST_END},
        '{FLT_MISALIGN,    1'b0, 32'd0,         1'b1, ST_ALIGN},
        '{FLT_ODD_SIZE,    1'b0, 32'd0,         1'b1, ST_ALIGN},
        '{FLT_NO_GLB,      1'b0, 32'd0,         1'b1, ST_END},
        '{FLT_LEN_CUT,     1'b0, 32'd0,         1'b1, ST_END},
        '{FLT_GLB_OVERRUN, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_END},
        '{FLT_PAD_MANY,    1'b1, 32'd8,         1'b1, ST_LENGTH},
        '{FLT_PAD_NZ,      1'b0, 32'd0,         1'b1, ST_LENGTH},
        '{FLT_NONE,        1'b1, 32'd0,         1'b0, ST_OK},
        '{FLT_NONE,        1'b1, 32'd7,         1'b0, ST_OK},
        '{FLT_NONE,        1'b0, 32'd0,         1'b0, ST_OK}
    };

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void tile_track_byte(input logic [7:0] b);
        logic [63:0] wbits;
        logic [35:0] len_pos;
        logic [35:0] k;
        wbits = 64'(b) << trk_shift;
        len_pos = 36'(trk_sum) + 36'(LEN_WORD_POS);
        if (trk_count < 4) begin
            if (b != TILE_MAGIC[trk_count[1:0]])
                trk_magic_ok = 1'b0;
        end else if (trk_count < 8) begin
            trk_version |= wbits[31:0];
        end else if (trk_count < 12) begin
            trk_declared |= wbits[31:0];
        end else if (trk_count < HEADER_BYTES) begin
            trk_sum += wbits[SUM_W-1:0];
        end else if (36'(trk_count) >= len_pos && 36'(trk_count) < len_pos + 36'd4) begin
            k = 36'(trk_count) - len_pos;
            trk_glb_len |= 32'(b) << {k[1:0], 3'b000};
        end
        trk_nz = {trk_nz[6:0], b != 8'd0};
        trk_shift += 5'd8;
        if (trk_count != 32'hFFFF_FFFF)
            trk_count++;
    endfunction

    // Judges the finished tile and clears the tracking state for the next one.
    function automatic t_result tile_verdict();
        t_result     r;
        logic [32:0] size;
        logic [35:0] glb_end;
        logic [35:0] trailing;
        logic [7:0]  pad_mask;
        r = '0;
        size = {1'b0, trk_count} + 33'(trk_count == 32'hFFFF_FFFF);
        glb_end = 36'(trk_sum) + 36'(trk_glb_len);
        trailing = 36'(size) - glb_end;
        pad_mask = (8'd1 << trailing[2:0]) - 8'd1;
        if (size < HEADER_BYTES)                           r.status = ST_END;
        else if (!trk_magic_ok)                            r.status = ST_MAGIC;
        else if (trk_version != cfg_version)               r.status = ST_VERSION;
        else if (33'(trk_declared) != size)                r.status = ST_LENGTH;
        else if (36'(trk_sum) > 36'(size))                 r.status = ST_END;
        else if (trk_sum[1:0] != 2'd0 || size[1:0] != 2'd0) r.status = ST_ALIGN;
        else if (36'(trk_sum) >= 36'(size))                r.status = ST_END;
        else if (36'(trk_sum) + 36'(LEN_WORD_END) > 36'(size)) r.status = ST_END;
        else if (glb_end > 36'(size))                      r.status = ST_END;
        else if (trailing > 36'(cfg_max_pad))              r.status = ST_LENGTH;
        else if (trailing > 36'(PAD_WINDOW))               r.status = ST_LENGTH;
        else if ((trk_nz & pad_mask) != 8'd0)              r.status = ST_LENGTH;
        else begin
            r.status              = ST_OK;
            r.glb_offset          = trk_sum[31:0];
            r.glb_length          = trk_glb_len;
            r.padding_bytes       = trailing[2:0];
            r.glb_offset_aligned  = (trk_sum[2:0] == 3'd0);
            r.tile_length_aligned = (size[2:0] == 3'd0);
        end
        trk_count    = '0;
        trk_shift    = '0;
        trk_magic_ok = 1'b1;
        trk_version  = '0;
        trk_declared = '0;
        trk_sum      = SUM_W'(HEADER_BYTES);
        trk_glb_len  = '0;
        trk_nz       = '0;
        return r;
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            tile_bytes.push_back(w[8*i +: 8]);
    endfunction

    // Builds one tile into tile_bytes: random noise, or a well-formed layout with at most one fault.
    function automatic void shape_tile(input tile_fault_t fault, input bit use_arg,
                                       input logic [31:0] arg);
        logic [31:0] sec [4];
        logic [31:0] version;
        logic [31:0] glb_len;
        logic [31:0] delta;
        logic [31:0] declared;
        logic [7:0]  glb_head [12];
        int          magic_bad;
        int          sec_fill;
        int          glb_fill;
        int          pad;
        int          cut;
        int          k;
        int          amount;
        bit          pad_dirty;
        tile_bytes.delete();
        if (fault == FLT_NOISE) begin
            if (use_arg)
                tile_bytes.push_back(arg[7:0]);
            else
                repeat ($urandom_range(1, 40)) tile_bytes.push_back(8'($urandom()));
            return;
        end
        magic_bad = -1;
        version   = cfg_version;
        delta     = 32'd0;
        cut       = 0;
        pad_dirty = 1'b0;
        sec_fill  = 0;
        for (int i = 0; i < 4; i++) begin
            sec[i] = 32'(4 * $urandom_range(0, 3));
            sec_fill += int'(sec[i]);
        end
        if (use_arg && (fault == FLT_NONE || fault == FLT_PAD_MANY))
            pad = int'(arg);
        else if (fault == FLT_PAD_MANY)
            pad = cfg_max_pad + 1 + $urandom_range(0, 4);
        else
            pad = $urandom_range(0, cfg_max_pad);
        if (fault == FLT_PAD_NZ && pad == 0)
            pad = 1;
        // The GLB length is chosen so that the whole tile stays a multiple of four.
        glb_len  = 32'(12 + 4 * $urandom_range(0, 4) + (4 - pad % 4) % 4);
        glb_fill = int'(glb_len);

        case (fault)
            FLT_MAGIC: magic_bad = $urandom_range(0, 3);
            FLT_VERSION: version = use_arg ? arg : cfg_version ^ (32'd1 << $urandom_range(0, 31));
            FLT_LENGTH: begin
                delta = $urandom_range(1) ? 32'($urandom_range(1, 8)) : ($urandom() | 32'd1);
                if ($urandom_range(1))
                    delta = -delta;
            end
            FLT_MISALIGN: begin
                k = $urandom_range(0, 3);
                amount = $urandom_range(1, 3);
                sec[k] += 32'(amount);
                sec_fill += amount;
            end
            FLT_ODD_SIZE: pad += $urandom_range(1, 3);
            FLT_OVERRUN: begin
                if (use_arg) begin
                    for (int i = 0; i < 4; i++)
                        sec[i] = arg;
                end else begin
                    sec[$urandom_range(0, 3)] = $urandom() | 32'h0000_0100;
                end
            end
            FLT_NO_GLB: begin
                glb_fill = 0;
                pad = 0;
            end
            FLT_LEN_CUT: begin
                glb_fill = 4 * $urandom_range(1, 2);
                pad = 0;
            end
            FLT_GLB_OVERRUN: glb_len = use_arg ? arg : 32'(glb_fill + pad + 4 * $urandom_range(1, 64));
            FLT_PAD_NZ: pad_dirty = 1'b1;
            FLT_SHORT: cut = use_arg ? int'(arg) : $urandom_range(1, 27);
            default: ;
        endcase

        glb_head = '{8'h67, 8'h6C, 8'h54, 8'h46, 8'h02, 8'h00, 8'h00, 8'h00,
                     glb_len[7:0], glb_len[15:8], glb_len[23:16], glb_len[31:24]};
        for (int i = 0; i < 4; i++)
            tile_bytes.push_back(i == magic_bad ? TILE_MAGIC[i] ^ 8'($urandom_range(1, 255))
                                                : TILE_MAGIC[i]);
        put_word(version);
        put_word(32'd0);
        for (int i = 0; i < 4; i++)
            put_word(sec[i]);
        repeat (sec_fill) tile_bytes.push_back(8'($urandom()));
        for (int i = 0; i < glb_fill; i++)
            tile_bytes.push_back(i < 12 ? glb_head[i] : 8'($urandom()));
        repeat (pad) tile_bytes.push_back(8'd0);
        if (pad_dirty)
            tile_bytes[tile_bytes.size() - 1 - $urandom_range(0, pad - 1)] =
                8'($urandom_range(1, 255));
        declared = 32'(tile_bytes.size()) + delta;
        for (int i = 0; i < 4; i++)
            tile_bytes[8 + i] = declared[8*i +: 8];
        if (cut > 0)
            while (tile_bytes.size() > cut) void'(tile_bytes.pop_back());
    endfunction

    // Offers every byte of tile_bytes, then files the verdict the block owes for it.
    task automatic send_tile(input bit typed, input t_status typed_status);
        t_result verdict;
        for (int i = 0; i < tile_bytes.size(); i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
            push        <= 1'b1;
            i_data_byte <= tile_bytes[i];
            i_last_byte <= (i == tile_bytes.size() - 1);
            do @(posedge i_clk); while (full);
            tile_track_byte(tile_bytes[i]);
            bytes_sent++;
        end
        verdict = tile_verdict();
        if (typed) begin
            verdict = '0;
            verdict.status = typed_status;
        end
        awaited_verdicts.push_back(verdict);
        tiles_sent++;
    endtask

    // Writes both registers once the block has drained.
    task automatic program_config(input logic [31:0] version, input logic [2:0] max_pad);
        push <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SUPPORTED_VERSION;
        i_cfg_data <= version;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_PADDING;
        i_cfg_data <= {29'd0, max_pad};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_version = version;
        cfg_max_pad = max_pad;
    endtask

    task automatic run_random(input int sender_pct, input int receiver_pct,
                              input int min_bytes, input int min_tiles);
        int          b0;
        int          t0;
        int          roll;
        tile_fault_t fault;
        send_idle_pct = sender_pct;
        stall_pct = receiver_pct;
        b0 = bytes_sent;
        t0 = tiles_sent;
        while (bytes_sent - b0 < min_bytes || tiles_sent - t0 < min_tiles) begin
            roll = $urandom_range(99);
            if (roll < 50)
                fault = FLT_NONE;
            else if (roll < 90)
                fault = tile_fault_t'($urandom_range(int'(FLT_MAGIC), int'(FLT_SHORT)));
            else
                fault = FLT_NOISE;
            shape_tile(fault, 1'b0, 32'd0);
            send_tile(1'b0, ST_OK);
        end
    endtask

    function automatic void flag_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_verdict();
        t_result want;
        if (awaited_verdicts.size() == 0) begin
            $display("%0t: result word with nothing awaited, expected none, got status %0d",
                     $time, o_status);
            mismatches++;
            return;
        end
        want = awaited_verdicts.pop_front();
        flag_field("status", 32'(want.status), 32'(o_status));
        flag_field("glb_offset", want.glb_offset, o_glb_offset);
        flag_field("glb_length", want.glb_length, o_glb_length);
        flag_field("padding_bytes", 32'(want.padding_bytes), 32'(o_padding_bytes));
        flag_field("glb_offset_aligned", 32'(want.glb_offset_aligned),
                   32'(o_glb_offset_aligned));
        flag_field("tile_length_aligned", 32'(want.tile_length_aligned),
                   32'(o_tile_length_aligned));
    endfunction

    // Result side: checks each word taken, then picks pop for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            check_verdict();
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed tiles under the reset configuration.
        foreach (probe_table[i]) begin
            shape_tile(probe_table[i].fault, probe_table[i].use_arg, probe_table[i].arg);
            send_tile(probe_table[i].typed, probe_table[i].status);
        end

        program_config(32'hFFFF_FFFF, 3'd0);
        run_random(0, 0, 120, 14);
        program_config(32'd1, 3'd7);
        run_random(65, 0, 120, 14);
        program_config($urandom(), 3'($urandom_range(1, 6)));
        run_random(0, 65, 120, 14);
        program_config(32'd0, 3'd3);
        run_random(38, 38, 120, 14);

        // The receiver holds off while mostly one-byte tiles keep coming, so the input stalls.
        program_config($urandom(), 3'd7);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b1;
        for (int n = 0; n < 40; n++) begin
            if (n % 4 == 3)
                shape_tile(FLT_NONE, 1'b0, 32'd0);
            else
                shape_tile(FLT_NOISE, 1'b1, 32'($urandom_range(255)));
            send_tile(1'b0, ST_OK);
        end

        push <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
